// ===== rtl/uvs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package uvs_pkg;
  localparam int SegmentBits = 8;
  localparam int FracBits = 14;
  localparam int CordicSteps = 24;
  localparam int QueueDepth = 2;
  localparam logic [31:0] CordicInvGain = 32'd652032874;
  localparam logic [31:0] VNudge = 32'd42950;

  typedef enum logic [0:0] {
    REG_WIDTH_SEG  = 1'b0,
    REG_HEIGHT_SEG = 1'b1
  } reg_idx_e;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] t;
    begin
      unique case (i)
        5'd0: t = 32'h20000000;
        5'd1: t = 32'h12E4051E;
        5'd2: t = 32'h09FB385B;
        5'd3: t = 32'h051111D4;
        5'd4: t = 32'h028B0D43;
        5'd5: t = 32'h0145D7E1;
        5'd6: t = 32'h00A2F61E;
        5'd7: t = 32'h00517C55;
        5'd8: t = 32'h0028BE53;
        5'd9: t = 32'h00145F2F;
        5'd10: t = 32'h000A2F98;
        5'd11: t = 32'h000517CC;
        5'd12: t = 32'h00028BE6;
        5'd13: t = 32'h000145F3;
        5'd14: t = 32'h0000A2FA;
        5'd15: t = 32'h0000517D;
        5'd16: t = 32'h000028BE;
        5'd17: t = 32'h0000145F;
        5'd18: t = 32'h00000A30;
        5'd19: t = 32'h00000518;
        5'd20: t = 32'h0000028C;
        5'd21: t = 32'h00000146;
        5'd22: t = 32'h000000A3;
        5'd23: t = 32'h00000051;
        default: t = 32'h0;
      endcase
      return t;
    end
  endfunction

  // One vertex as classified by the walker
  typedef struct packed {
    logic [9:0]  row;
    logic [9:0]  col;
    logic [9:0]  w;
    logic [9:0]  h;
    logic [15:0] base;
  } vtx_t;
endpackage
`default_nettype wire

// ===== rtl/uv_sphere_tessellator.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Path from input transaction to result transaction: the walker queue, then
//   three 42-step divisions by the segment counts, two 24-step CORDIC runs,
//   two multiplies, pack. The engine takes a vertex only when idle with no
//   result pending; the walker queues up to two requests.
// Reset: asynchronous, active low; walk returns to the origin, segments 32/16.
module uv_sphere_tessellator #(
  parameter int SEGMENT_BITS = uvs_pkg::SegmentBits,
  parameter int FRAC_BITS = uvs_pkg::FracBits
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  s_tvalid_i,
  output logic                 s_tready_o,
  input  wire  [7:0]           s_tdata_i,   // [0] restart
  output logic                 m_tvalid_o,
  input  wire                  m_tready_i,
  // pos_x, pos_y, pos_z, tex_u, tex_v, corner_a..d, 16 bits each from bit 0
  output logic [143:0]         m_tdata_o,
  output logic [1:0]           m_tuser_o,   // [0] upper_tri_valid, [1] lower_tri_valid
  output logic                 m_tlast_o,
  input  wire                  psel,
  input  wire                  penable,
  input  wire                  pwrite,
  input  wire  [2:0]           paddr,
  input  wire  [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import uvs_pkg::*;

  logic [SEGMENT_BITS-1:0] wseg_q, hseg_q;
  logic cfg_wr;
  logic wr_en, wseg_sel, hseg_sel;
  logic q_valid, q_ready;
  vtx_t q_vtx;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite && pready;
  assign wseg_sel = (paddr == {REG_WIDTH_SEG, 2'b00});
  assign hseg_sel = (paddr == {REG_HEIGHT_SEG, 2'b00});
  assign cfg_wr = wr_en && (wseg_sel || hseg_sel);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wseg_q <= SEGMENT_BITS'(32);
      hseg_q <= SEGMENT_BITS'(16);
    end else if (wr_en) begin
      if (wseg_sel) wseg_q <= pwdata[SEGMENT_BITS-1:0];
      else if (hseg_sel) hseg_q <= pwdata[SEGMENT_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (wseg_sel) prdata = 32'(wseg_q);
    else if (hseg_sel) prdata = 32'(hseg_q);
  end

  uvs_walker #(.SEG_BITS(SEGMENT_BITS)) u_walk (
    .clk_i, .rst_ni, .s_tvalid_i, .s_tready_o, .restart_i(s_tdata_i[0]),
    .cfg_wr_i(cfg_wr), .wseg_i(wseg_q), .hseg_i(hseg_q),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_vtx_o(q_vtx)
  );

  uvs_engine #(.FRAC(FRAC_BITS)) u_eng (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_ready_o(q_ready), .q_vtx_i(q_vtx),
    .m_tvalid_o, .m_tready_i, .m_tdata_o, .m_tuser_o, .m_tlast_o
  );
endmodule
`default_nettype wire

// ===== rtl/uvs_walker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module uvs_walker #(
  parameter int SEG_BITS = uvs_pkg::SegmentBits
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    s_tvalid_i,
  output logic                   s_tready_o,
  input  wire                    restart_i,
  input  wire                    cfg_wr_i,
  input  wire  [SEG_BITS-1:0]    wseg_i,
  input  wire  [SEG_BITS-1:0]    hseg_i,
  output logic                   q_valid_o,
  input  wire                    q_ready_i,
  output uvs_pkg::vtx_t          q_vtx_o
);
  import uvs_pkg::*;

  logic [SEG_BITS-1:0] row_q, row_d, col_q, col_d;
  logic [15:0] base_q, base_d;
  logic [SEG_BITS:0] w, h;
  logic [SEG_BITS-1:0] r, c;
  logic [15:0] b;
  logic fire;

  // Queue between the walker and the math back end
  vtx_t q_mem [QueueDepth];
  logic [$clog2(QueueDepth)-1:0] wp_q, rp_q;
  logic [$clog2(QueueDepth):0] cnt_q;

  assign w = (wseg_i < SEG_BITS'(3)) ? (SEG_BITS+1)'(3) : {1'b0, wseg_i};
  assign h = (hseg_i < SEG_BITS'(2)) ? (SEG_BITS+1)'(2) : {1'b0, hseg_i};
  assign s_tready_o = (cnt_q != ($clog2(QueueDepth)+1)'(QueueDepth));
  assign fire = s_tvalid_i && s_tready_o;
  assign r = restart_i ? '0 : row_q;
  assign c = restart_i ? '0 : col_q;
  assign b = restart_i ? '0 : base_q;

  always_comb begin
    row_d = r;
    col_d = c;
    base_d = b;
    if ({1'b0, c} < w) begin
      col_d = c + 1'b1;
    end else if ({1'b0, r} < h) begin
      col_d = '0;
      row_d = r + 1'b1;
      base_d = b + 16'(w) + 16'd1;
    end else begin
      row_d = '0;
      col_d = '0;
      base_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
      base_q <= '0;
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (cfg_wr_i) begin
        row_q <= '0;
        col_q <= '0;
        base_q <= '0;
      end else if (fire) begin
        row_q <= row_d;
        col_q <= col_d;
        base_q <= base_d;
      end
      if (fire) wp_q <= wp_q + 1'b1;
      if (q_valid_o && q_ready_i) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + ($clog2(QueueDepth)+1)'(fire)
               - ($clog2(QueueDepth)+1)'(q_valid_o && q_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      q_mem[wp_q] <= '{row: 10'(r), col: 10'(c), w: 10'(w), h: 10'(h), base: b};
    end
  end

  assign q_valid_o = (cnt_q != '0);
  assign q_vtx_o = q_mem[rp_q];
endmodule
`default_nettype wire

// ===== rtl/uvs_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider: quotient of num by den, one bit per cycle
module uvs_divider (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start_i,
  input  wire  [41:0] num_i,
  input  wire  [9:0]  den_i,
  output logic        done_o,
  output logic [41:0] quot_o
);
  logic [41:0] n_q;
  logic [10:0] rem_q;
  logic [9:0] den_q;
  logic [5:0] cnt_q;
  logic busy_q;
  logic [11:0] trial;

  assign trial = {rem_q, n_q[41]} - {2'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= 6'd42;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quot_o <= '0;
    end else if (busy_q) begin
      n_q <= {n_q[40:0], 1'b0};
      if (!trial[11]) begin
        rem_q <= trial[10:0];
        quot_o <= {quot_o[40:0], 1'b1};
      end else begin
        rem_q <= {rem_q[9:0], n_q[41]};
        quot_o <= {quot_o[40:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/uvs_cordic.sv =====
`timescale 1ns / 1ps
`default_nettype none
module uvs_cordic (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start_i,
  input  wire  [31:0] phase_i,
  output logic        done_o,
  output logic signed [32:0] cos_o,
  output logic signed [32:0] sin_o
);
  import uvs_pkg::*;

  logic signed [32:0] x_q, y_q;
  logic signed [32:0] z_q;
  logic [1:0] quad_q;
  logic [4:0] i_q;
  logic busy_q;
  logic signed [32:0] dx, dy, at;

  assign dx = y_q >>> i_q;
  assign dy = x_q >>> i_q;
  assign at = signed'({1'b0, atan_turn(i_q)});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      i_q <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        i_q <= '0;
      end else if (busy_q) begin
        i_q <= i_q + 1'b1;
        if (i_q == 5'(CordicSteps - 1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quad_q <= phase_i[31:30];
      z_q <= signed'({3'b0, phase_i[29:0]});
      x_q <= signed'({1'b0, CordicInvGain});
      y_q <= '0;
    end else if (busy_q) begin
      if (!z_q[32]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + at;
      end
    end
  end

  always_comb begin
    unique case (quad_q)
      2'd0: begin cos_o = x_q; sin_o = y_q; end
      2'd1: begin cos_o = -y_q; sin_o = x_q; end
      2'd2: begin cos_o = -x_q; sin_o = -y_q; end
      default: begin cos_o = y_q; sin_o = -x_q; end
    endcase
  end
endmodule
`default_nettype wire

// ===== rtl/uvs_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
module uvs_engine #(
  parameter int FRAC = uvs_pkg::FracBits
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                q_valid_i,
  output logic               q_ready_o,
  input  uvs_pkg::vtx_t      q_vtx_i,
  output logic               m_tvalid_o,
  input  wire                m_tready_i,
  output logic [143:0]       m_tdata_o,
  output logic [1:0]         m_tuser_o,
  output logic               m_tlast_o
);
  import uvs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV_U, S_DIV_V, S_DIV_O, S_COR_T, S_COR_P, S_MUL_X, S_MUL_Z, S_PACK
  } state_e;

  state_e state_q;
  vtx_t v_q;
  logic [32:0] u32_q, vq_q;
  logic [31:0] off_q;
  logic signed [32:0] ct_q, st_q, cp_q, sp_q;
  logic signed [65:0] px_q, pz_q;
  logic dv_start, dv_done, co_start, co_done;
  logic [41:0] dv_num, dv_quot;
  logic [9:0] dv_den;
  logic [31:0] co_phase;
  logic signed [32:0] co_cos, co_sin;
  logic out_full_q;
  logic signed [32:0] mul_a;
  logic signed [65:0] prod;

  assign prod = mul_a * sp_q;

  function automatic logic [15:0] sat_round(input logic signed [66:0] v, input int sh);
    logic signed [66:0] t;
    begin
      t = (v + (67'sd1 <<< (sh - 1))) >>> sh;
      if (t > 67'sd32767) return 16'h7FFF;
      if (t < -67'sd32768) return 16'h8000;
      return t[15:0];
    end
  endfunction

  uvs_divider u_div (
    .clk_i, .rst_ni, .start_i(dv_start), .num_i(dv_num), .den_i(dv_den),
    .done_o(dv_done), .quot_o(dv_quot)
  );
  uvs_cordic u_cor (
    .clk_i, .rst_ni, .start_i(co_start), .phase_i(co_phase),
    .done_o(co_done), .cos_o(co_cos), .sin_o(co_sin)
  );

  assign q_ready_o = (state_q == S_IDLE) && !out_full_q;

  always_comb begin
    dv_start = 1'b0;
    dv_num = '0;
    dv_den = v_q.w;
    co_start = 1'b0;
    co_phase = u32_q[31:0];
    mul_a = ct_q;
    unique case (state_q)
      S_IDLE: begin
        dv_start = q_valid_i && q_ready_o;
        dv_num = {q_vtx_i.col, 32'b0} + 42'(q_vtx_i.w[9:1]);
        dv_den = q_vtx_i.w;
      end
      S_DIV_U: begin
        dv_start = dv_done;
        dv_num = {v_q.row, 32'b0} + 42'(v_q.h[9:1]);
        dv_den = v_q.h;
      end
      S_DIV_V: begin
        dv_start = dv_done;
        dv_num = 42'h80000000 + 42'(v_q.w[9:1]);
        dv_den = v_q.w;
      end
      S_DIV_O: begin
        co_start = dv_done;
        co_phase = u32_q[31:0];
      end
      S_COR_T: begin
        co_start = co_done;
        co_phase = vq_q[32:1];
      end
      S_MUL_Z: mul_a = st_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_full_q <= 1'b0;
    end else begin
      if (m_tvalid_o && m_tready_i) out_full_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (q_valid_i && q_ready_o) state_q <= S_DIV_U;
        S_DIV_U: if (dv_done) state_q <= S_DIV_V;
        S_DIV_V: if (dv_done) state_q <= S_DIV_O;
        S_DIV_O: if (dv_done) state_q <= S_COR_T;
        S_COR_T: if (co_done) state_q <= S_COR_P;
        S_COR_P: if (co_done) state_q <= S_MUL_X;
        S_MUL_X: state_q <= S_MUL_Z;
        S_MUL_Z: state_q <= S_PACK;
        S_PACK: begin
          out_full_q <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && q_valid_i && q_ready_o) v_q <= q_vtx_i;
    if (state_q == S_DIV_U && dv_done) u32_q <= dv_quot[32:0];
    if (state_q == S_DIV_V && dv_done) vq_q <= dv_quot[32:0] + 33'(VNudge);
    if (state_q == S_DIV_O && dv_done) off_q <= dv_quot[31:0];
    if (state_q == S_COR_T && co_done) begin
      ct_q <= co_cos;
      st_q <= co_sin;
    end
    if (state_q == S_COR_P && co_done) begin
      cp_q <= co_cos;
      sp_q <= co_sin;
    end
    if (state_q == S_MUL_X) px_q <= prod;
    if (state_q == S_MUL_Z) pz_q <= prod;
  end

  logic signed [34:0] tu;
  logic signed [34:0] tv;
  logic quad;
  logic [15:0] cb, cc;
  logic [143:0] pack;

  always_comb begin
    tu = signed'({2'b0, u32_q});
    if (v_q.row == '0) tu = tu + signed'({3'b0, off_q});
    else if (v_q.row == v_q.h) tu = tu - signed'({3'b0, off_q});
    tv = 35'sh100000000 - signed'({2'b0, vq_q});
    quad = (v_q.row < v_q.h) && (v_q.col < v_q.w);
    cb = v_q.base + 16'(v_q.col);
    cc = cb + 16'(v_q.w) + 16'd1;
    pack = '0;
    pack[15:0] = sat_round(67'(px_q), 60 - FRAC);
    pack[31:16] = sat_round(67'(cp_q), 30 - FRAC);
    pack[47:32] = sat_round(67'(pz_q), 60 - FRAC);
    pack[63:48] = sat_round(67'(tu), 32 - FRAC);
    pack[79:64] = sat_round(67'(tv), 32 - FRAC);
    pack[95:80] = quad ? cb + 16'd1 : 16'd0;
    pack[111:96] = quad ? cb : 16'd0;
    pack[127:112] = quad ? cc : 16'd0;
    pack[143:128] = quad ? cc + 16'd1 : 16'd0;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_PACK) begin
      m_tdata_o <= pack;
      m_tuser_o <= {quad && (v_q.row != v_q.h - 10'd1), quad && (v_q.row != '0)};
      m_tlast_o <= (v_q.row == v_q.h) && (v_q.col == v_q.w);
    end
  end

  assign m_tvalid_o = out_full_q;
endmodule
`default_nettype wire
